### design/vgl_pkg.sv
// Package with shared constants, command and status types for the volume stencil.
`timescale 1ns / 1ps

package vgl_pkg;

    localparam int MAX_SIZE_X = 256;
    localparam int MAX_SIZE_Y = 256;
    localparam int MAX_SIZE_Z = 4096;

    localparam int XW = $clog2(MAX_SIZE_X);
    localparam int YW = $clog2(MAX_SIZE_Y);
    localparam int ZW = $clog2(MAX_SIZE_Z);
    localparam int AW = 1 + XW + YW;

    localparam int SAMPLE_W = 17;
    localparam int GRAD_W = 18;
    localparam int LAP_W = 21;
    localparam int SUM_W = 35;
    localparam int ROOT_STEPS = 18;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [2:0] SEL_C = 3'd0;
    localparam logic [2:0] SEL_PX = 3'd1;
    localparam logic [2:0] SEL_NX = 3'd2;
    localparam logic [2:0] SEL_PY = 3'd3;
    localparam logic [2:0] SEL_NY = 3'd4;
    localparam logic [2:0] SEL_NZ = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       wr_en;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic       emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic interior;
        logic out_full;
    } dp_status_t;

endpackage

### design/volume_gradient_laplacian_stencil.sv
// Top level of the seven-point gradient and Laplacian volume stencil.
`timescale 1ns / 1ps
// Voxels enter in raster order on the s_ stream, one per transfer, x fastest.
// Each interior voxel, one plane behind the voxel just taken, gives one result
// transfer on the m_ stream with its value, gradient, Laplacian and running
// extremes; m_tlast marks the last interior voxel of the volume.
// Border voxels give no result. Sizes are to be set on the cfg_ port only
// while idle; the block itself does not enforce this. Any size write restarts
// the volume and keeps the running extremes. An item that gives no result
// passes through the input transfer and one write; one that gives a result
// passes through the input transfer, six reads of the single plane memory
// port, one write, three square steps, the one-bit-per-step square root and
// the load of the output register. While a result waits in the output
// register, the next items are still taken; the block stalls only when a new
// result is ready and the register is full. Reset clears positions, sizes to
// 256, extremes and the output valid; the plane memory is not cleared and is
// always written before it is read.
module volume_gradient_laplacian_stencil (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // sample[16:0], zero fill above
    output logic         m_tvalid,
    input  logic         m_tready,
    // centre_value, grad_twice, laplace, value_low, value_high, grad_low,
    // grad_high, laplace_low, laplace_high, from the lowest bit up
    output logic [167:0] m_tdata,
    output logic         m_tlast,   // final_res
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [12:0]  cfg_data
);

    vgl_pkg::ctrl_cmd_t  cmd;
    vgl_pkg::dp_status_t status;
    logic                ready;

    assign s_tready = ready;

    vgl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (s_tvalid & ready),
        .status  (status),
        .ready   (ready),
        .cmd     (cmd)
    );

    vgl_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .sample    (s_tdata[16:0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### design/vgl_ctrl.sv
// State machine that sequences reads, write, squares, root steps and emit.
`timescale 1ns / 1ps

module vgl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  vgl_pkg::dp_status_t status,
    output logic                ready,
    output vgl_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_SQUARE = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       inter_reg, inter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= 5'd0;
            inter_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            inter_reg <= inter_next;
        end
    end

    assign ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        inter_next = inter_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    inter_next = status.interior;
                    cnt_next = 5'd0;
                    state_next = status.interior ? ST_READ : ST_WRITE;
                end
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = cnt_reg[2:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[2:0] == vgl_pkg::SEL_NZ)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_en = 1'b1;
                cnt_next = 5'd0;
                state_next = inter_reg ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE:
            begin
                cmd.sq_en = 1'b1;
                cmd.sq_sel = cnt_reg[1:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == vgl_pkg::AXIS_Z)
                begin
                    cnt_next = 5'd0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    cmd.root_init = 1'b1;
                end
                else
                begin
                    cmd.root_step = 1'b1;
                end
                if (cnt_reg == 5'(vgl_pkg::ROOT_STEPS))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_full) else $error("emit into a full output register");
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !cmd.wr_en) else $error("read and write in one cycle");
    a_root_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && cnt_reg == 5'(vgl_pkg::ROOT_STEPS)) |=> state_reg == ST_EMIT)
        else $error("root sequence did not end in emit");
`endif

endmodule

### design/vgl_datapath.sv
// Datapath with plane memory, position counters, arithmetic, square root and extremes.
`timescale 1ns / 1ps

module vgl_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  vgl_pkg::ctrl_cmd_t  cmd,
    output vgl_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [12:0]         cfg_data,
    input  logic [16:0]         sample,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [167:0]        out_data,
    output logic                out_last
);

    localparam int XW = vgl_pkg::XW;
    localparam int YW = vgl_pkg::YW;
    localparam int ZW = vgl_pkg::ZW;

    logic [8:0]  sx_reg, sy_reg;
    logic [12:0] sz_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [ZW-1:0] z_reg;

    logic signed [16:0] mem [0:(1 << vgl_pkg::AW) - 1];
    logic signed [16:0] rdata_reg;
    logic               rd_vld_reg;
    logic [2:0]         rd_sel_reg;
    logic signed [16:0] nb_reg [0:5];
    logic signed [16:0] sample_reg;
    logic               final_reg;

    logic [vgl_pkg::SUM_W-1:0] sum_reg;
    logic signed [20:0]        lap_reg;
    logic [vgl_pkg::SUM_W-1:0] v_reg, r_reg, bit_reg;

    logic signed [16:0] vmin_reg, vmax_reg;
    logic [17:0]        gmin_reg, gmax_reg;
    logic signed [20:0] lmin_reg, lmax_reg;
    logic               oval_reg;
    logic [167:0]       odata_reg;
    logic               olast_reg;

    logic [8:0]  x1, y1;
    logic [12:0] z1;
    logic        interior, last_vox;
    logic        pb;
    logic        cfg_hit;
    logic [vgl_pkg::AW-1:0] rd_addr, wr_addr;

    function automatic logic [12:0] clamp_size(input logic [12:0] v, input int hi);
        logic [12:0] r;
        r = v;
        if (v < 13'd3) r = 13'd3;
        else if (v > 13'(hi)) r = 13'(hi);
        return r;
    endfunction

    assign x1 = 9'(x_reg) + 9'd1;
    assign y1 = 9'(y_reg) + 9'd1;
    assign z1 = 13'(z_reg) + 13'd1;
    assign interior = (x_reg != '0) && (x1 < sx_reg) && (y_reg != '0) && (y1 < sy_reg)
                      && (z_reg >= ZW'(2));
    assign last_vox = (x1 + 9'd1 == sx_reg) && (y1 + 9'd1 == sy_reg) && (z1 == sz_reg);
    assign pb = ~z_reg[0];
    assign wr_addr = {z_reg[0], y_reg, x_reg};
    assign cfg_hit = cfg_we && (cfg_addr == vgl_pkg::CFG_SIZE_X
                                || cfg_addr == vgl_pkg::CFG_SIZE_Y
                                || cfg_addr == vgl_pkg::CFG_SIZE_Z);

    always_comb
    begin
        case (cmd.rd_sel)
            vgl_pkg::SEL_C:  rd_addr = {pb, y_reg, x_reg};
            vgl_pkg::SEL_PX: rd_addr = {pb, y_reg, x_reg + XW'(1)};
            vgl_pkg::SEL_NX: rd_addr = {pb, y_reg, x_reg - XW'(1)};
            vgl_pkg::SEL_PY: rd_addr = {pb, y_reg + YW'(1), x_reg};
            vgl_pkg::SEL_NY: rd_addr = {pb, y_reg - YW'(1), x_reg};
            default:         rd_addr = {z_reg[0], y_reg, x_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= sample_reg;
        end
    end

    assign status.interior = interior;
    assign status.out_full = oval_reg;

    // Configuration and raster position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= 9'd256;
            sy_reg <= 9'd256;
            sz_reg <= 13'd256;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_addr)
                vgl_pkg::CFG_SIZE_X:
                    sx_reg <= 9'(clamp_size({4'd0, cfg_data[8:0]}, vgl_pkg::MAX_SIZE_X));
                vgl_pkg::CFG_SIZE_Y:
                    sy_reg <= 9'(clamp_size({4'd0, cfg_data[8:0]}, vgl_pkg::MAX_SIZE_Y));
                default:
                    sz_reg <= clamp_size(cfg_data, vgl_pkg::MAX_SIZE_Z);
            endcase
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            if (x1 >= sx_reg)
            begin
                x_reg <= '0;
                if (y1 >= sy_reg)
                begin
                    y_reg <= '0;
                    z_reg <= (z1 >= sz_reg) ? '0 : z1[ZW-1:0];
                end
                else
                begin
                    y_reg <= y1[YW-1:0];
                end
            end
            else
            begin
                x_reg <= x1[XW-1:0];
            end
        end
    end

    // Operand capture, squares, Laplacian and square root.
    logic signed [17:0] diff;
    logic signed [35:0] prod;
    logic signed [20:0] lap_term;
    logic [vgl_pkg::SUM_W:0] trial;

    always_comb
    begin
        case (cmd.sq_sel)
            vgl_pkg::AXIS_X:
            begin
                diff = 18'(nb_reg[1]) - 18'(nb_reg[2]);
                lap_term = 21'(nb_reg[1]) + 21'(nb_reg[2]) - (21'(nb_reg[0]) <<< 2)
                           - (21'(nb_reg[0]) <<< 1);
            end
            vgl_pkg::AXIS_Y:
            begin
                diff = 18'(nb_reg[3]) - 18'(nb_reg[4]);
                lap_term = lap_reg + 21'(nb_reg[3]) + 21'(nb_reg[4]);
            end
            default:
            begin
                diff = 18'(sample_reg) - 18'(nb_reg[5]);
                lap_term = lap_reg + 21'(sample_reg) + 21'(nb_reg[5]);
            end
        endcase
        prod = diff * diff;
        trial = {1'b0, v_reg} - ({1'b0, r_reg} + {1'b0, bit_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_sel_reg <= cmd.rd_sel;
        if (rd_vld_reg)
        begin
            nb_reg[rd_sel_reg] <= rdata_reg;
        end
        if (cmd.load)
        begin
            sample_reg <= sample;
            final_reg <= last_vox;
        end
        if (cmd.sq_en)
        begin
            sum_reg <= ((cmd.sq_sel == vgl_pkg::AXIS_X) ? '0 : sum_reg) + prod[34:0];
            lap_reg <= lap_term;
        end
        if (cmd.root_init)
        begin
            v_reg <= sum_reg;
            r_reg <= '0;
            bit_reg <= 35'd1 << 34;
        end
        else if (cmd.root_step)
        begin
            if (!trial[vgl_pkg::SUM_W])
            begin
                v_reg <= trial[vgl_pkg::SUM_W-1:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Running extremes and output register.
    logic [17:0]        g;
    logic signed [16:0] vmin_n, vmax_n;
    logic [17:0]        gmin_n, gmax_n;
    logic signed [20:0] lmin_n, lmax_n;

    always_comb
    begin
        g = r_reg[17:0];
        vmin_n = (nb_reg[0] < vmin_reg) ? nb_reg[0] : vmin_reg;
        vmax_n = (nb_reg[0] > vmax_reg) ? nb_reg[0] : vmax_reg;
        gmin_n = (g < gmin_reg) ? g : gmin_reg;
        gmax_n = (g > gmax_reg) ? g : gmax_reg;
        lmin_n = (lap_reg < lmin_reg) ? lap_reg : lmin_reg;
        lmax_n = (lap_reg > lmax_reg) ? lap_reg : lmax_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmin_reg <= 17'sh0FFFF;
            vmax_reg <= 17'sh10000;
            gmin_reg <= 18'h3FFFF;
            gmax_reg <= 18'h00000;
            lmin_reg <= 21'sh0FFFFF;
            lmax_reg <= 21'sh100000;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                vmin_reg <= vmin_n;
                vmax_reg <= vmax_n;
                gmin_reg <= gmin_n;
                gmax_reg <= gmax_n;
                lmin_reg <= lmin_n;
                lmax_reg <= lmax_n;
                oval_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            odata_reg <= {lmax_n, lmin_n, gmax_n, gmin_n, vmax_n, vmin_n, lap_reg, g,
                          nb_reg[0]};
            olast_reg <= final_reg;
        end
    end

    assign out_valid = oval_reg;
    assign out_data = odata_reg;
    assign out_last = olast_reg;

endmodule

### sim/volume_gradient_laplacian_stencil_test.sv
// Testbench for the seven-point gradient and Laplacian volume stencil.
`timescale 1ns / 1ps

module volume_gradient_laplacian_stencil_test;

    localparam int LIMIT_CYCLES = 800000;
    localparam int SETTLE_CYCLES = 64;

    typedef enum logic [1:0] {JOB_VOXEL, JOB_SIZE, JOB_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [1:0]  sel;
        logic [16:0] val;
        logic [12:0] cfg;
        bit          steady;
    } job_t;

    typedef struct {
        logic [167:0] fields;
        logic         last;
    } stencil_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [12:0]  cfg_data;

    job_t            job_q[$];
    stencil_result_t stencil_q[$];

    int      voxel_mem [0:131071];
    int      dim_x, dim_y, dim_z;
    int      col, row, pln;
    longint  val_lo, val_hi, grad_lo, grad_hi, lap_lo, lap_hi;

    bit      took;
    bit      steady;
    bit      fill_steady;
    int      quiet;
    int      cycle;
    int      errors;
    int      voxels_in;
    int      results_seen;
    int      finals_seen;
    int      size_writes;

    volume_gradient_laplacian_stencil dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int clamp_dim(int v, int hi);
        if (v < 3)
        begin
            return 3;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic int mem_index(int p, int y, int x);
        return ((p & 1) << 16) + ((y % vgl_pkg::MAX_SIZE_Y) << 8) + (x % vgl_pkg::MAX_SIZE_X);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic apply_size(logic [1:0] sel, logic [12:0] data);
        if (sel == vgl_pkg::CFG_SIZE_X)
        begin
            dim_x = clamp_dim(int'(data[8:0]), vgl_pkg::MAX_SIZE_X);
        end
        else if (sel == vgl_pkg::CFG_SIZE_Y)
        begin
            dim_y = clamp_dim(int'(data[8:0]), vgl_pkg::MAX_SIZE_Y);
        end
        else if (sel == vgl_pkg::CFG_SIZE_Z)
        begin
            dim_z = clamp_dim(int'(data), vgl_pkg::MAX_SIZE_Z);
        end
        else
        begin
            return;
        end
        col = 0;
        row = 0;
        pln = 0;
    endtask

    task automatic take_voxel(logic [16:0] raw);
        int              x, y, z, pv;
        longint          s, c, px, nx, py, ny, nz, dx, dy, dz, g, a;
        longint unsigned sq;
        stencil_result_t r;
        x = col;
        y = row;
        z = pln;
        s = $signed(raw);
        if (x >= 1 && x + 1 < dim_x && y >= 1 && y + 1 < dim_y && z >= 2)
        begin
            pv = z + 1;
            c  = voxel_mem[mem_index(pv, y, x)];
            px = voxel_mem[mem_index(pv, y, x + 1)];
            nx = voxel_mem[mem_index(pv, y, x - 1)];
            py = voxel_mem[mem_index(pv, y + 1, x)];
            ny = voxel_mem[mem_index(pv, y - 1, x)];
            nz = voxel_mem[mem_index(z, y, x)];
            dx = px - nx;
            dy = py - ny;
            dz = s - nz;
            sq = dx * dx + dy * dy + dz * dz;
            g  = longint'(floor_root(sq));
            a  = px + nx + py + ny + s + nz - 6 * c;
            if (c < val_lo) val_lo = c;
            if (c > val_hi) val_hi = c;
            if (g < grad_lo) grad_lo = g;
            if (g > grad_hi) grad_hi = g;
            if (a < lap_lo) lap_lo = a;
            if (a > lap_hi) lap_hi = a;
            r.fields = {lap_hi[20:0], lap_lo[20:0], grad_hi[17:0], grad_lo[17:0],
                        val_hi[16:0], val_lo[16:0], a[20:0], g[17:0], c[16:0]};
            r.last = (x + 2 == dim_x && y + 2 == dim_y && z + 1 == dim_z);
            stencil_q.push_back(r);
        end
        voxel_mem[mem_index(z, y, x)] = int'(s);
        if (x + 1 >= dim_x)
        begin
            col = 0;
            if (y + 1 >= dim_y)
            begin
                row = 0;
                pln = (z + 1 >= dim_z) ? 0 : z + 1;
            end
            else
            begin
                row = y + 1;
            end
        end
        else
        begin
            col = x + 1;
        end
    endtask

    task automatic check_result(logic [167:0] act, logic act_last);
        stencil_result_t e;
        int              fw [9];
        int              off;
        logic [20:0]     ef, af;
        bit              bad;
        fw = '{17, 18, 21, 17, 17, 18, 18, 21, 21};
        if (stencil_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result %h last %b", act, act_last);
            return;
        end
        e = stencil_q.pop_front();
        bad = (e.last !== act_last);
        off = 0;
        for (int i = 0; i < 9; i++)
        begin
            ef = (e.fields >> off) & ((168'd1 << fw[i]) - 1);
            af = (act >> off) & ((168'd1 << fw[i]) - 1);
            if (ef !== af)
            begin
                bad = 1;
                if (errors < 10)
                    $display("ERROR: result %0d field %0d expected %h got %h",
                             results_seen, i, ef, af);
            end
            off += fw[i];
        end
        if (bad)
        begin
            errors++;
            if (errors <= 10 && e.last !== act_last)
                $display("ERROR: result %0d last expected %b got %b",
                         results_seen, e.last, act_last);
        end
    endtask

    // Monitor: applies size writes and accepted voxels to the prediction and checks results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle++;
            if (cycle > LIMIT_CYCLES)
            begin
                $display("Timeout after %0d cycles", cycle);
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                if (m_tvalid && m_tready)
                begin
                    check_result(m_tdata, m_tlast);
                    results_seen++;
                    if (m_tlast)
                        finals_seen++;
                end
                if (cfg_we)
                begin
                    apply_size(cfg_addr, cfg_data);
                    size_writes++;
                end
                if (s_tvalid && s_tready)
                begin
                    take_voxel(s_tdata[16:0]);
                    voxels_in++;
                end
                took <= s_tvalid && s_tready;
                quiet <= (stencil_q.size() == 0 && !s_tvalid) ? quiet + 1 : 0;
            end
        end
    end

    // Driver and receiver: inputs change on the falling edge.
    always @(negedge clk)
    begin
        job_t p;
        bit   nv;
        bit   nwe;
        nv = s_tvalid && !took;
        nwe = 0;
        if (rst_n && !nv && job_q.size() > 0)
        begin
            p = job_q[0];
            case (p.kind)
                JOB_VOXEL:
                begin
                    steady = p.steady;
                    if (steady || $urandom_range(0, 99) >= 26)
                    begin
                        nv = 1;
                        s_tdata <= {7'd0, p.val};
                        void'(job_q.pop_front());
                    end
                end
                JOB_SIZE:
                begin
                    if (stencil_q.size() == 0 && quiet >= SETTLE_CYCLES)
                    begin
                        nwe = 1;
                        cfg_addr <= p.sel;
                        cfg_data <= p.cfg;
                        void'(job_q.pop_front());
                    end
                end
                default:
                begin
                    if (stencil_q.size() == 0)
                        void'(job_q.pop_front());
                end
            endcase
        end
        s_tvalid <= nv;
        cfg_we <= nwe;
        m_tready <= rst_n && (steady || $urandom_range(0, 99) >= 26);
    end

    task automatic push_size(logic [12:0] sx, logic [12:0] sy, logic [12:0] sz);
        job_t j;
        j.kind = JOB_SIZE;
        j.val = '0;
        j.steady = 0;
        j.sel = vgl_pkg::CFG_SIZE_X;
        j.cfg = sx;
        job_q.push_back(j);
        j.sel = vgl_pkg::CFG_SIZE_Y;
        j.cfg = sy;
        job_q.push_back(j);
        j.sel = vgl_pkg::CFG_SIZE_Z;
        j.cfg = sz;
        job_q.push_back(j);
    endtask

    task automatic push_voxel(int v);
        job_t j;
        j.kind = JOB_VOXEL;
        j.sel = vgl_pkg::CFG_SIZE_X;
        j.cfg = '0;
        j.val = v[16:0];
        j.steady = fill_steady;
        job_q.push_back(j);
    endtask

    function automatic int draw_voxel(int mode, int base);
        if (mode == 0)
            return $urandom_range(0, 98303) - 32768;
        if (mode == 1)
            return base + $urandom_range(0, 40) - 20;
        return base;
    endfunction

    task automatic push_volume(int count);
        int mode, base;
        mode = $urandom_range(0, 2);
        base = $urandom_range(0, 60000) - 20000;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 199) == 0)
            begin
                job_t d;
                d.kind = JOB_DRAIN;
                d.sel = vgl_pkg::CFG_SIZE_X;
                d.val = '0;
                d.cfg = '0;
                d.steady = 0;
                job_q.push_back(d);
            end
            push_voxel(draw_voxel(mode, base));
        end
    endtask

    initial
    begin
        int sx, sy, sz, vol, reports;
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_we = 0;
        cfg_addr = vgl_pkg::CFG_SIZE_X;
        cfg_data = '0;
        took = 0;
        steady = 0;
        fill_steady = 0;
        quiet = 0;
        cycle = 0;
        errors = 0;
        voxels_in = 0;
        results_seen = 0;
        finals_seen = 0;
        size_writes = 0;
        dim_x = 256;
        dim_y = 256;
        dim_z = 256;
        col = 0;
        row = 0;
        pln = 0;
        val_lo = 65535;
        val_hi = -65536;
        grad_lo = 262143;
        grad_hi = 0;
        lap_lo = 1048575;
        lap_hi = -1048576;

        // Sizes below the minimum clamp to 3; two volumes stress the value extremes.
        push_size(13'd0, 13'd1, 13'd2);
        for (int i = 0; i < 27; i++)
            push_voxel(i == 13 ? -32768 : 65535);
        for (int i = 0; i < 27; i++)
            push_voxel(i == 13 ? 65535 : (i % 2 ? -32768 : 65535));

        // Oversized writes clamp to the maxima; a few voxels stream before the next write.
        push_size(13'h1FFF, 13'd3, 13'h1FFF);
        push_volume(20);
        push_size(13'd3, 13'd300, 13'd4096);
        push_volume(20);

        // Back-to-back volumes with no size write between them.
        push_size(13'd4, 13'd4, 13'd3);
        push_volume(2 * 48);

        // A volume cut short by a size write.
        push_size(13'd5, 13'd5, 13'd5);
        push_volume(40);

        reports = 0;
        vol = 0;
        while (reports < 20 || vol < 4)
        begin
            sx = $urandom_range(3, 6);
            sy = $urandom_range(3, 5);
            sz = $urandom_range(3, 4);
            fill_steady = (vol == 1 || vol == 2);
            push_size(sx[12:0], sy[12:0], sz[12:0]);
            push_volume(sx * sy * sz);
            reports += (sx - 2) * (sy - 2) * (sz - 2);
            vol++;
        end
        fill_steady = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        wait (job_q.size() == 0);
        @(posedge clk);
        while (s_tvalid || stencil_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Streamed %0d voxels over %0d size writes, %0d random volumes.",
                 voxels_in, size_writes, vol);
        $display("Checked %0d results, %0d of them closing a volume.", results_seen, finals_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
design/vgl_pkg.sv
design/vgl_ctrl.sv
design/vgl_datapath.sv
design/volume_gradient_laplacian_stencil.sv
sim/volume_gradient_laplacian_stencil_test.sv
